// ----- rtl/dhcpos_pkg.sv -----
// ----------------------------------------------------------------------------
// dhcpos_pkg
// Shared types and constants of the DHCP option search block: transfer
// payloads, the classified byte passed from front to back, option codes.
// ----------------------------------------------------------------------------
package dhcpos_pkg;

   // option codes with a fixed meaning
   localparam logic [7:0] CODE_PAD      = 8'd0;
   localparam logic [7:0] CODE_END      = 8'd255;
   localparam logic [7:0] CODE_OVERLOAD = 8'd52;

   // area codes
   localparam logic [1:0] AREA_OPTIONS = 2'd0;
   localparam logic [1:0] AREA_FILE    = 2'd1;
   localparam logic [1:0] AREA_SNAME   = 2'd2;
   localparam int         AREA_COUNT   = 3;

   // configuration register indexes and reset values
   localparam logic       CSR_TARGET_CODE   = 1'b0;
   localparam logic       CSR_MIN_SIZE      = 1'b1;
   localparam logic [7:0] TARGET_CODE_RESET = 8'd53;
   localparam logic [7:0] MIN_SIZE_RESET    = 8'd1;

   // byte position counter, saturating
   localparam int         POS_W   = 9;
   localparam logic [8:0] POS_MAX = 9'd511;

   // front to back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [1:0] area;
      logic [8:0] tag_position;
      logic [7:0] value_length;
   } rsp_type;

   // byte with its classification flags
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic       last;
      logic       is_pad;
      logic       is_end;
      logic       is_target;
      logic       is_overload;
      logic       len_ok;
   } item_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

endpackage

// ----- rtl/dhcp_option_search.sv -----
// ----------------------------------------------------------------------------
// dhcp_option_search
// Walks the options, file and sname areas of a DHCP message streamed one
// byte per transfer and reports the first acceptable target option, with
// the overload option deciding which extra areas count.
//
//  channel  | ports                          | dir | payload
//  ---------+--------------------------------+-----+--------------------------
//  request  | req_valid, req_stall, req_data | in  | mode, data_byte, last
//  response | rsp_valid, rsp_stall, rsp_data | out | found, area, position, len
//  csr      | csr_write, csr_index, csr_wdata| in  | target_code, min_size
//
// One byte is taken every cycle while the queue has room (req_stall is
// high while it is full). A final byte is first written into the queue;
// the walkers then pop it from the queue head and register the result in
// the output register. Reset is synchronous and needs no clearing pass.
// A four-entry queue lets the request side run while a result is stalled.
// ----------------------------------------------------------------------------
module dhcp_option_search #(
   parameter int OPTIONS_BYTES = 312,
   parameter int FILE_BYTES    = 128,
   parameter int SNAME_BYTES   = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dhcpos_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dhcpos_pkg::rsp_type rsp_data,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [7:0]          csr_wdata
);
   import dhcpos_pkg::*;

   qhead_type q_head;
   logic      q_pop;

   // classify and queue
   dhcpos_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   // walkers and result
   dhcpos_back #(
      .OPTIONS_BYTES (OPTIONS_BYTES),
      .FILE_BYTES    (FILE_BYTES),
      .SNAME_BYTES   (SNAME_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/dhcpos_front.sv -----
// ----------------------------------------------------------------------------
// dhcpos_front
// Holds the configuration registers, classifies each accepted byte against
// the option codes and the search settings, and queues it for the back end.
// ----------------------------------------------------------------------------
module dhcpos_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dhcpos_pkg::req_type  req_data,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [7:0]           csr_wdata,
   output dhcpos_pkg::qhead_type q_head,
   input  logic                 q_pop
);
   import dhcpos_pkg::*;

   localparam logic [QUEUE_CNT_W-1:0] DEPTH = QUEUE_CNT_W'(QUEUE_DEPTH);

   logic [7:0]             target_ff;
   logic [7:0]             min_size_ff;
   item_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   item_type               cls;
   logic                   push;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TARGET_CODE_RESET;
         min_size_ff <= MIN_SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TARGET_CODE: target_ff   <= csr_wdata;
            CSR_MIN_SIZE:    min_size_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // classify the incoming byte
   always_comb begin
      cls.mode        = req_data.mode;
      cls.data_byte   = req_data.data_byte;
      cls.last        = req_data.last;
      cls.is_pad      = (req_data.data_byte == CODE_PAD);
      cls.is_end      = (req_data.data_byte == CODE_END);
      cls.is_target   = (req_data.data_byte == target_ff);
      cls.is_overload = (req_data.data_byte == CODE_OVERLOAD);
      cls.len_ok      = (req_data.data_byte >= min_size_ff);
   end

   // queue control
   assign req_stall = (count_ff == DEPTH);
   assign push      = req_valid && !req_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = mem_ff[rd_ptr_ff];

   // queue checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH)
      else $error("queue count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == DEPTH) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("full queue with unequal pointers");

endmodule

// ----- rtl/dhcpos_back.sv -----
// ----------------------------------------------------------------------------
// dhcpos_back
// Three option walkers, one per area, advanced by the queued bytes. On the
// final byte the match is chosen with the overload rules and placed in the
// output register; walker phases, positions, hit flags and the overload flag then clear.
// ----------------------------------------------------------------------------
module dhcpos_back #(
   parameter int OPTIONS_BYTES = 312,
   parameter int FILE_BYTES    = 128,
   parameter int SNAME_BYTES   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dhcpos_pkg::qhead_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dhcpos_pkg::rsp_type   rsp_data
);
   import dhcpos_pkg::*;

   typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_SKIP, PH_STOP} phase_type;

   item_type   it;
   logic       clear;

   // per-area walker state
   phase_type  phase_ff       [AREA_COUNT];
   phase_type  phase_in       [AREA_COUNT];
   logic [8:0] count_ff       [AREA_COUNT];
   logic [8:0] count_in       [AREA_COUNT];
   logic [7:0] skip_ff        [AREA_COUNT];
   logic [7:0] skip_in        [AREA_COUNT];
   logic       pend_match_ff  [AREA_COUNT];
   logic       pend_match_in  [AREA_COUNT];
   logic       pend_ovl_ff    [AREA_COUNT];
   logic       pend_ovl_in    [AREA_COUNT];
   logic [8:0] pend_off_ff    [AREA_COUNT];
   logic [8:0] pend_off_in    [AREA_COUNT];
   logic       hit_seen_ff    [AREA_COUNT];
   logic       hit_seen_in    [AREA_COUNT];
   logic [8:0] hit_off_ff     [AREA_COUNT];
   logic [8:0] hit_off_in     [AREA_COUNT];
   logic [7:0] hit_len_ff     [AREA_COUNT];
   logic [7:0] hit_len_in     [AREA_COUNT];

   // overload option, options area only
   logic       ovl_seen_ff;
   logic       ovl_seen_in;
   logic [1:0] ovl_bits_ff;
   logic [1:0] ovl_bits_in;
   logic       ovl_take;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    rsp_data_in;

   assign it    = q_head.item;
   // a final byte needs a free output register
   assign q_pop = q_head.valid && !(it.last && rsp_valid_ff && rsp_stall);
   assign clear = q_pop && it.last;

   for (genvar g = 0; g < AREA_COUNT; g++) begin : g_lane
      localparam int LIM_I = (g == 0) ? OPTIONS_BYTES :
                             (g == 1) ? FILE_BYTES : SNAME_BYTES;
      localparam logic [9:0] LIM = 10'(LIM_I);

      logic       act;
      logic [9:0] pos;

      assign act = q_pop && (it.mode == 2'(g));
      assign pos = {1'b0, count_ff[g]};

      // tag-length-value walk of one byte
      always_comb begin
         phase_type ph;
         ph               = phase_ff[g];
         count_in[g]      = count_ff[g];
         skip_in[g]       = skip_ff[g];
         pend_match_in[g] = pend_match_ff[g];
         pend_ovl_in[g]   = pend_ovl_ff[g];
         pend_off_in[g]   = pend_off_ff[g];
         hit_seen_in[g]   = hit_seen_ff[g];
         hit_off_in[g]    = hit_off_ff[g];
         hit_len_in[g]    = hit_len_ff[g];
         if (act) begin
            if (ph != PH_STOP && pos >= LIM) begin
               ph = PH_STOP;
            end
            unique case (ph)
               PH_TAG: begin
                  if (it.is_end) begin
                     ph = PH_STOP;
                  end else if (!it.is_pad) begin
                     if (pos + 10'd2 >= LIM) begin
                        ph = PH_STOP;
                     end else begin
                        pend_match_in[g] = it.is_target;
                        pend_ovl_in[g]   = it.is_overload;
                        pend_off_in[g]   = count_ff[g];
                        ph               = PH_LEN;
                     end
                  end
               end
               PH_LEN: begin
                  if ({1'b0, pend_off_ff[g]} + 10'd2 + {2'b00, it.data_byte} >= LIM) begin
                     ph = PH_STOP;
                  end else if (pend_match_ff[g] && it.len_ok) begin
                     hit_seen_in[g] = 1'b1;
                     hit_off_in[g]  = pend_off_ff[g];
                     hit_len_in[g]  = it.data_byte;
                     ph             = PH_STOP;
                  end else if (it.is_pad) begin
                     ph = PH_TAG;
                  end else begin
                     skip_in[g] = it.data_byte;
                     ph         = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  skip_in[g] = skip_ff[g] - 8'd1;
                  if (skip_ff[g] == 8'd1) begin
                     ph = PH_TAG;
                  end
               end
               PH_STOP: ;
               default: ;
            endcase
            if (pos + 10'd1 >= LIM) begin
               ph = PH_STOP;
            end
            if (count_ff[g] != POS_MAX) begin
               count_in[g] = count_ff[g] + 9'd1;
            end
         end
         phase_in[g] = ph;
      end

      // first value byte of the overload option
      if (g == 0) begin : g_ovl
         assign ovl_take = act && phase_ff[g] == PH_SKIP && pos < LIM
                           && pend_ovl_ff[g] && !ovl_seen_ff
                           && pos == {1'b0, pend_off_ff[g]} + 10'd2;
      end

      // walker registers
      always_ff @(posedge clock) begin
         if (reset || clear) begin
            phase_ff[g]    <= PH_TAG;
            count_ff[g]    <= '0;
            hit_seen_ff[g] <= 1'b0;
         end else begin
            phase_ff[g]    <= phase_in[g];
            count_ff[g]    <= count_in[g];
            hit_seen_ff[g] <= hit_seen_in[g];
         end
         skip_ff[g]       <= skip_in[g];
         pend_match_ff[g] <= pend_match_in[g];
         pend_ovl_ff[g]   <= pend_ovl_in[g];
         pend_off_ff[g]   <= pend_off_in[g];
         hit_off_ff[g]    <= hit_off_in[g];
         hit_len_ff[g]    <= hit_len_in[g];
      end
   end

   assign ovl_seen_in = ovl_seen_ff || ovl_take;
   assign ovl_bits_in = ovl_take ? it.data_byte[1:0] : ovl_bits_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         ovl_seen_ff <= 1'b0;
      end else begin
         ovl_seen_ff <= ovl_seen_in;
      end
      ovl_bits_ff <= ovl_bits_in;
   end

   // choose the reported match
   always_comb begin
      rsp_data_in = '0;
      if (hit_seen_in[0]) begin
         rsp_data_in.found        = 1'b1;
         rsp_data_in.area         = AREA_OPTIONS;
         rsp_data_in.tag_position = hit_off_in[0];
         rsp_data_in.value_length = hit_len_in[0];
      end else if (ovl_seen_in && ovl_bits_in[0] && hit_seen_in[1]) begin
         rsp_data_in.found        = 1'b1;
         rsp_data_in.area         = AREA_FILE;
         rsp_data_in.tag_position = hit_off_in[1];
         rsp_data_in.value_length = hit_len_in[1];
      end else if (ovl_seen_in && ovl_bits_in[1] && hit_seen_in[2]) begin
         rsp_data_in.found        = 1'b1;
         rsp_data_in.area         = AREA_SNAME;
         rsp_data_in.tag_position = hit_off_in[2];
         rsp_data_in.value_length = hit_len_in[2];
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (clear) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (clear) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // result and clearing checks
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      clear |=> rsp_valid_ff)
      else $error("final byte gave no result");

   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |->
         (rsp_data_ff.area == '0 && rsp_data_ff.tag_position == '0
          && rsp_data_ff.value_length == '0))
      else $error("empty result carries non-zero fields");

   a_clear_walkers: assert property (@(posedge clock) disable iff (reset)
      clear |=> (count_ff[0] == '0 && count_ff[1] == '0 && count_ff[2] == '0
                 && !ovl_seen_ff && phase_ff[0] == PH_TAG))
      else $error("walkers not cleared after final byte");

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dhcp_option_search. Streams DHCP option areas one
// byte per transfer, mirrors the three option walkers and the overload rule
// in a local predictor, and checks every result against it field by field.
// Starts with a few hand-built messages, then moves to random messages under
// several register settings, the extremes among them, with random idling, then a burst without idling.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dhcpos_pkg::*;

   localparam int OPTIONS_BYTES = 312;
   localparam int FILE_BYTES    = 128;
   localparam int SNAME_BYTES   = 64;
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PRINT_LIMIT   = 50;

   // area code that no walker owns
   localparam logic [1:0] AREA_UNUSED = 2'd3;

   typedef enum logic [1:0] {WALK_TAG, WALK_LEN, WALK_SKIP, WALK_STOP} walk_stage_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic    csr_index = CSR_TARGET_CODE;
   logic [7:0] csr_wdata = '0;

   int gap_pct      = 31;
   int stall_pct    = 31;
   int sent_count   = 0;
   int error_count  = 0;
   int quiet_cycles = 0;

   // search results still to come out of the block, oldest first
   rsp_type expected_search[$];
   // message under construction
   req_type msg_bytes[$];

   // predictor copy of the registers and of the walkers
   logic [7:0]     target_cfg;
   logic [7:0]     min_len_cfg;
   walk_stage_type stage_of[AREA_COUNT];
   int             offset_cnt[AREA_COUNT];
   logic [7:0]     value_left[AREA_COUNT];
   logic [7:0]     held_code[AREA_COUNT];
   int             held_offset[AREA_COUNT];
   bit             hit_flag[AREA_COUNT];
   logic [8:0]     hit_offset_q[AREA_COUNT];
   logic [7:0]     hit_len_q[AREA_COUNT];
   bit             ovl_seen;
   logic [1:0]     ovl_bits;

   dhcp_option_search #(
      .OPTIONS_BYTES (OPTIONS_BYTES),
      .FILE_BYTES    (FILE_BYTES),
      .SNAME_BYTES   (SNAME_BYTES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int area_limit(input int a);
      if (a == AREA_OPTIONS) return OPTIONS_BYTES;
      if (a == AREA_FILE) return FILE_BYTES;
      return SNAME_BYTES;
   endfunction

   function automatic void clear_search();
      for (int a = 0; a < AREA_COUNT; a++) begin
         stage_of[a]     = WALK_TAG;
         offset_cnt[a]   = 0;
         value_left[a]   = '0;
         held_code[a]    = '0;
         held_offset[a]  = 0;
         hit_flag[a]     = 1'b0;
         hit_offset_q[a] = '0;
         hit_len_q[a]    = '0;
      end
      ovl_seen = 1'b0;
      ovl_bits = '0;
   endfunction

   // one byte through the walker of its area
   function automatic void walk_area(input int a, input logic [7:0] b);
      int lim;
      int o;
      lim = area_limit(a);
      o   = offset_cnt[a];
      // a byte read at or past the area end stops the walker
      if (stage_of[a] != WALK_STOP && o >= lim) stage_of[a] = WALK_STOP;
      case (stage_of[a])
         WALK_TAG: begin
            if (b == CODE_END) begin
               stage_of[a] = WALK_STOP;
            end else if (b != CODE_PAD) begin
               if (o + 2 >= lim) begin
                  stage_of[a] = WALK_STOP;
               end else begin
                  held_code[a]   = b;
                  held_offset[a] = o;
                  stage_of[a]    = WALK_LEN;
               end
            end
         end
         WALK_LEN: begin
            if (held_offset[a] + 2 + int'(b) >= lim) begin
               stage_of[a] = WALK_STOP;
            end else if (held_code[a] == target_cfg && b >= min_len_cfg) begin
               hit_flag[a]     = 1'b1;
               hit_offset_q[a] = 9'(held_offset[a]);
               hit_len_q[a]    = b;
               stage_of[a]     = WALK_STOP;
            end else if (b == 8'd0) begin
               stage_of[a] = WALK_TAG;
            end else begin
               value_left[a] = b;
               stage_of[a]   = WALK_SKIP;
            end
         end
         WALK_SKIP: begin
            // first value byte of the first overload option
            if (a == AREA_OPTIONS && held_code[a] == CODE_OVERLOAD && !ovl_seen
                && o == held_offset[a] + 2) begin
               ovl_seen = 1'b1;
               ovl_bits = b[1:0];
            end
            value_left[a] = value_left[a] - 8'd1;
            if (value_left[a] == 8'd0) stage_of[a] = WALK_TAG;
         end
         default: ;
      endcase
      if (o + 1 >= lim) stage_of[a] = WALK_STOP;
      if (o < POS_MAX) offset_cnt[a] = o + 1;
   endfunction

   // returns 1 when the byte closes a message, with the search result
   function automatic bit predict_byte(input req_type it, output rsp_type res);
      int pick;
      res  = '0;
      pick = -1;
      if (it.mode inside {AREA_OPTIONS, AREA_FILE, AREA_SNAME})
         walk_area(int'(it.mode), it.data_byte);
      if (!it.last) return 1'b0;
      // options area wins, then overload decides file and sname
      if (hit_flag[AREA_OPTIONS])
         pick = AREA_OPTIONS;
      else if (ovl_seen && ovl_bits[0] && hit_flag[AREA_FILE])
         pick = AREA_FILE;
      else if (ovl_seen && ovl_bits[1] && hit_flag[AREA_SNAME])
         pick = AREA_SNAME;
      if (pick >= 0) begin
         res.found        = 1'b1;
         res.area         = 2'(pick);
         res.tag_position = hit_offset_q[pick];
         res.value_length = hit_len_q[pick];
      end
      clear_search();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // receiver stalls and result check
   always @(posedge clock) begin
      rsp_type want;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_search.size() == 0) begin
            report_mismatch($sformatf("result with none due: %p", rsp_data));
         end else begin
            want = expected_search.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found %b, want %b", rsp_data.found, want.found));
            if (rsp_data.area !== want.area)
               report_mismatch($sformatf("area %0d, want %0d", rsp_data.area, want.area));
            if (rsp_data.tag_position !== want.tag_position)
               report_mismatch($sformatf("tag_position %0d, want %0d",
                                         rsp_data.tag_position, want.tag_position));
            if (rsp_data.value_length !== want.value_length)
               report_mismatch($sformatf("value_length %0d, want %0d",
                                         rsp_data.value_length, want.value_length));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // one byte transfer, with random gaps ahead of it
   task automatic send_byte(input req_type it);
      rsp_type res;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_byte(it, res)) expected_search.push_back(res);
      sent_count++;
   endtask

   function automatic void put(input logic [1:0] m, input logic [7:0] b);
      msg_bytes.push_back('{mode: m, data_byte: b, last: 1'b0});
   endfunction

   // mark the final byte and stream the whole message
   task automatic send_message();
      if (msg_bytes.size() == 0) put(2'($urandom_range(3)), 8'($urandom));
      msg_bytes[$].last = 1'b1;
      foreach (msg_bytes[i]) send_byte(msg_bytes[i]);
      msg_bytes.delete();
   endtask

   // random options for one area, cut off after cap bytes
   function automatic void add_area(input int a, input int cap, input bit want_target);
      int n;
      int pick;
      logic [7:0] code;
      logic [7:0] len;
      n = 0;
      while (n < cap) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            put(2'(a), CODE_PAD);
            n++;
         end else if (pick < 11) begin
            put(2'(a), CODE_END);
            n++;
         end else begin
            if (pick < 40 && want_target) code = target_cfg;
            else if (pick < 55) code = CODE_OVERLOAD;
            else code = 8'($urandom_range(1, 254));
            pick = $urandom_range(99);
            if (pick < 12) len = min_len_cfg;
            else if (pick < 18) len = min_len_cfg - 8'd1;
            else if (pick < 24) len = 8'($urandom_range(255));
            else if (pick < 30) len = 8'd0;
            else len = 8'($urandom_range(1, 6));
            put(2'(a), code);
            n++;
            if (n < cap) begin
               put(2'(a), len);
               n++;
            end
            for (int j = 0; j < len && n < cap; j++) begin
               put(2'(a), 8'($urandom));
               n++;
            end
         end
      end
   endfunction

   task automatic random_message();
      int first;
      int a;
      int cap;
      if ($urandom_range(9) == 0) begin
         // noise: arbitrary bytes in arbitrary areas
         repeat ($urandom_range(1, 15)) put(2'($urandom_range(3)), 8'($urandom));
      end else begin
         first = $urandom_range(AREA_COUNT - 1);
         for (int k = 0; k < AREA_COUNT; k++) begin
            a = (first + k) % AREA_COUNT;
            // now and then a whole area and a few bytes past its end
            if ($urandom_range(24) == 0) cap = area_limit(a) + $urandom_range(6);
            else cap = $urandom_range(16);
            add_area(a, cap, a != AREA_OPTIONS || $urandom_range(1) == 1);
         end
         if ($urandom_range(19) == 0)
            msg_bytes.insert($urandom_range(msg_bytes.size()),
                             '{mode: AREA_UNUSED, data_byte: 8'($urandom), last: 1'b0});
      end
      send_message();
   endtask

   // wait until every search result is out and the block has gone quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_search.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] code, input logic [7:0] size);
      wait_idle();
      csr_write   <= 1'b1;
      csr_index   <= CSR_TARGET_CODE;
      csr_wdata   <= code;
      target_cfg   = code;
      @(posedge clock);
      csr_index   <= CSR_MIN_SIZE;
      csr_wdata   <= size;
      min_len_cfg  = size;
      @(posedge clock);
      csr_write   <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // hand-built messages under the reset register values
   task automatic test_directed();
      // match behind a pad, stray byte of the unused area code
      put(AREA_OPTIONS, CODE_PAD);
      put(AREA_OPTIONS, TARGET_CODE_RESET);
      put(AREA_OPTIONS, 8'd1);
      put(AREA_OPTIONS, 8'hAA);
      put(AREA_UNUSED, 8'hFF);
      put(AREA_SNAME, 8'h00);
      send_message();
      // overload admits file; options target too short, then end code
      put(AREA_OPTIONS, CODE_OVERLOAD);
      put(AREA_OPTIONS, 8'd1);
      put(AREA_OPTIONS, 8'h03);
      put(AREA_OPTIONS, TARGET_CODE_RESET);
      put(AREA_OPTIONS, 8'd0);
      put(AREA_OPTIONS, CODE_END);
      put(AREA_FILE, TARGET_CODE_RESET);
      put(AREA_FILE, 8'd2);
      put(AREA_FILE, 8'h5A);
      put(AREA_FILE, 8'hC3);
      put(AREA_SNAME, TARGET_CODE_RESET);
      put(AREA_SNAME, 8'd1);
      put(AREA_SNAME, 8'h55);
      send_message();
      // option value running past the file area end
      put(AREA_FILE, 8'h07);
      put(AREA_FILE, 8'hFF);
      put(AREA_OPTIONS, CODE_END);
      send_message();
      // lone final byte holding a tag
      put(AREA_OPTIONS, TARGET_CODE_RESET);
      send_message();
   endtask

   // random messages under a run of register settings
   task automatic test_random_settings();
      logic [7:0] codes[7];
      logic [7:0] sizes[7];
      int stop_at;
      codes = '{8'd1, 8'd254, CODE_PAD, CODE_END, TARGET_CODE_RESET,
                8'($urandom_range(1, 254)), 8'($urandom_range(1, 254))};
      sizes = '{8'd0, 8'd255, 8'd3, 8'd1, MIN_SIZE_RESET,
                8'($urandom_range(255)), 8'($urandom_range(0, 4))};
      foreach (codes[p]) begin
         apply_settings(codes[p], sizes[p]);
         stop_at = sent_count + 120;
         while (sent_count < stop_at) random_message();
      end
   endtask

   // back-to-back transfers with no idling on either side
   task automatic test_no_idle_burst();
      int stop_at;
      gap_pct   = 0;
      stall_pct = 0;
      apply_settings(8'($urandom_range(1, 254)), 8'($urandom_range(0, 4)));
      // sname bytes far past the area end: position counter saturates
      repeat (520) put(AREA_SNAME, CODE_PAD);
      send_message();
      stop_at = sent_count + 130;
      while (sent_count < stop_at) random_message();
      gap_pct   = 31;
      stall_pct = 31;
   endtask

   initial begin
      clear_search();
      target_cfg  = TARGET_CODE_RESET;
      min_len_cfg = MIN_SIZE_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_settings();
      test_no_idle_burst();
      wait_idle();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- dhcp_option_search.f -----
rtl/dhcpos_pkg.sv
rtl/dhcpos_front.sv
rtl/dhcpos_back.sv
rtl/dhcp_option_search.sv
verif/tb.sv
